/* rtl/pfhc_pkg.sv */
// Package for the pixel float-to-half converter: payload types and constants.
// No dependencies.
`default_nettype none
package pfhc_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;
  localparam logic [15:0] HalfInf   = 16'h7C00;
  localparam logic [15:0] HalfQnan  = 16'h7E00;
  localparam logic [15:0] HalfMant  = 16'h03FF;
  localparam logic [12:0] RemHalf   = 13'h1000;
  localparam logic [0:0]  OrderBgra = 1'b0;
  localparam logic [0:0]  OrderArgb = 1'b1;
  localparam logic [0:0]  RegPixelOrder = 1'b0;

  typedef struct packed {
    logic [31:0] host_word_0;
    logic [31:0] host_word_1;
    logic [31:0] host_word_2;
    logic [31:0] host_word_3;
    logic        first_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] red_half;
    logic [15:0] green_half;
    logic [15:0] blue_half;
    logic [15:0] alpha_half;
    logic        nan_seen;
    logic        inf_seen;
  } pix_out_t;

  // Lane class flags handed to the merging stage
  typedef struct packed {
    logic is_nan;
    logic is_inf;
  } half_class_t;
endpackage
`default_nettype wire

/* rtl/pfhc_stream_if.sv */
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a type parameter.
`default_nettype none
interface pfhc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/pixel_float_to_half_converter_unit.sv */
// Pixel float32-to-half converter, top level.
// The result is registered: valid in the cycle after an item is accepted.
// Throughput: one item per cycle while the output is taken; four conversion lanes run in parallel.
// Reset (synchronous, rst_n low): channel order BGRA, sticky flags clear,
// output register empty. Depends on pfhc_pkg, pfhc_stream_if, pfhc_lane, pfhc_merge.
`default_nettype none
module pixel_float_to_half_converter_unit
  import pfhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  pfhc_stream_if.sink      in_ch,
  pfhc_stream_if.source    out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic        order_r;
  logic        can_take, acc;
  logic [31:0] ch [4];
  logic [15:0] half [4];
  half_class_t cls [4];
  pix_in_t     p;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == RegPixelOrder) ? {31'd0, order_r} : 32'd0;

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= OrderBgra;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == RegPixelOrder) begin
      order_r <= cfg_pwdata[0];
    end
  end

  assign p = in_ch.payload;
  assign in_ch.ready = can_take;
  assign acc = in_ch.valid && can_take;

  // Pick words into R, G, B, A order
  always_comb begin
    if (order_r == OrderArgb) begin
      ch[0] = p.host_word_1; ch[1] = p.host_word_2;
      ch[2] = p.host_word_3; ch[3] = p.host_word_0;
    end else begin
      ch[0] = p.host_word_2; ch[1] = p.host_word_1;
      ch[2] = p.host_word_0; ch[3] = p.host_word_3;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    pfhc_lane u_lane (.word_i(ch[k]), .half_o(half[k]), .cls_o(cls[k]));
  end

  pfhc_merge u_merge (
    .clk(clk), .rst_n(rst_n), .acc_i(acc), .first_i(p.first_of_frame),
    .half_i(half), .cls_i(cls), .out_ready_i(out_ch.ready),
    .can_take_o(can_take), .out_valid_o(out_ch.valid), .out_o(out_ch.payload)
  );
endmodule
`default_nettype wire

/* rtl/pfhc_lane.sv */
// One conversion lane: float32 bits to half bits, round to nearest even.
// Depends on pfhc_pkg.
`default_nettype none
module pfhc_lane
  import pfhc_pkg::*;
(
  input  wire logic [31:0] word_i,
  output logic [15:0]      half_o,
  output half_class_t      cls_o
);
  logic        sign;
  logic [7:0]  bexp;
  logic [22:0] frac;
  logic [14:0] h;
  logic [12:0] rem;
  logic [4:0]  shift;
  logic [23:0] full, m, rmask, rrem, halfway;
  logic [14:0] mag_h;

  always_comb begin
    sign = word_i[31];
    bexp = word_i[30:23];
    frac = word_i[22:0];
    h = {5'(bexp - 8'd112), frac[22:13]};
    rem = frac[12:0];
    shift = 5'(8'd126 - bexp);
    full = {1'b1, frac};
    m = full >> shift;
    rmask = (24'd1 << shift) - 24'd1;
    rrem = full & rmask;
    halfway = 24'd1 << (shift - 5'd1);
    mag_h = '0;
    if (bexp == 8'hFF) begin
      // keep infinity, quieten NaN
      if (frac == '0) mag_h = HalfInf[14:0];
      else mag_h = HalfQnan[14:0] | {5'd0, frac[22:13]};
    end else if (bexp >= 8'd143) begin
      mag_h = HalfInf[14:0];
    end else if (bexp >= 8'd113) begin
      mag_h = h;
      if (rem > RemHalf || (rem == RemHalf && h[0])) mag_h = h + 15'd1;
    end else if (bexp == 8'd0 || bexp < 8'd102) begin
      mag_h = '0;
    end else begin
      // half subnormal: shift 14..24
      if (rrem > halfway || (rrem == halfway && m[0])) mag_h = 15'(m + 24'd1);
      else mag_h = 15'(m);
    end
    half_o = {sign, mag_h};
    cls_o.is_nan = (mag_h[14:10] == 5'h1F) && (mag_h[9:0] != '0);
    cls_o.is_inf = (mag_h[14:10] == 5'h1F) && (mag_h[9:0] == '0);
  end
endmodule
`default_nettype wire

/* rtl/pfhc_merge.sv */
// Merging stage: sticky flag update and registered output with skid-free
// hand-off (ready when output empty or being taken). Depends on pfhc_pkg.
`default_nettype none
module pfhc_merge
  import pfhc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc_i,
  input  wire logic        first_i,
  input  wire logic [15:0] half_i [4],
  input  wire half_class_t cls_i [4],
  input  wire logic        out_ready_i,
  output logic             can_take_o,
  output logic             out_valid_o,
  output pix_out_t         out_o
);
  logic nan_r, inf_r, nan_nxt, inf_nxt, vld_r;
  pix_out_t data_r;

  assign can_take_o = !vld_r || out_ready_i;
  assign out_valid_o = vld_r;
  assign out_o = data_r;

  // Combine lane classes into the sticky flags, cleared first on the first item of a frame
  always_comb begin
    nan_nxt = first_i ? 1'b0 : nan_r;
    inf_nxt = first_i ? 1'b0 : inf_r;
    for (int k = 0; k < 4; k++) begin
      nan_nxt = nan_nxt | cls_i[k].is_nan;
      inf_nxt = inf_nxt | cls_i[k].is_inf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nan_r <= 1'b0;
      inf_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      if (acc_i) begin
        nan_r <= nan_nxt;
        inf_r <= inf_nxt;
        vld_r <= 1'b1;
      end else if (out_ready_i) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i) begin
      data_r <= '{half_i[0], half_i[1], half_i[2], half_i[3], nan_nxt, inf_nxt};
    end
  end
endmodule
`default_nettype wire
